// File: rtl/slm_pkg.sv
package slm_pkg;

  localparam int unsigned LIST_DEPTH_DEF  = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    REQ_APPEND_A = 2'd0,
    REQ_APPEND_B = 2'd1,
    REQ_MERGE    = 2'd2
  } slm_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } slm_state_e;

endpackage

// File: rtl/slm_if.sv
interface slm_req_if #(
  parameter int unsigned VALUE_WIDTH = slm_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface slm_res_if #(
  parameter int unsigned VALUE_WIDTH = slm_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] merged_value;
  logic                          from_list_b;
  logic                          last_item;

  modport source (output valid, merged_value, from_list_b, last_item, input ready);
  modport sink   (input valid, merged_value, from_list_b, last_item, output ready);
endinterface

// File: rtl/slm_ram.sv
module slm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/slm_front.sv
module slm_front #(
  parameter int unsigned VALUE_WIDTH = slm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [VALUE_WIDTH-1:0] req_value_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output slm_pkg::slm_req_e      cmd_op_o,
  output logic [VALUE_WIDTH-1:0] cmd_value_o
);
  import slm_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  slm_req_e               op_q  [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_q [QUEUE_DEPTH];
  logic [PW-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [FW-1:0]          fill_q, fill_d;
  logic                   known, push, pop;

  always_comb begin
    unique case (req_type_i)
      REQ_APPEND_A, REQ_APPEND_B, REQ_MERGE: known = 1'b1;
      default:                               known = 1'b0;
    endcase
  end

  assign req_ready_o = (fill_q != FW'(QUEUE_DEPTH));
  assign push        = req_valid_i && req_ready_o && known;
  assign cmd_valid_o = (fill_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_op_o    = op_q[rd_q];
  assign cmd_value_o = val_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_q]  <= slm_req_e'(req_type_i);
      val_q[wr_q] <= req_value_i;
    end
  end

endmodule

// File: rtl/slm_back.sv
module slm_back #(
  parameter int unsigned LIST_DEPTH  = slm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = slm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  slm_pkg::slm_req_e      cmd_op_i,
  input  logic [VALUE_WIDTH-1:0] cmd_value_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [VALUE_WIDTH-1:0] res_value_o,
  output logic                   res_from_b_o,
  output logic                   res_last_o
);
  import slm_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  slm_state_e             st_q, st_d;
  logic [CW-1:0]          cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]          pos_a_q, pos_a_d, pos_b_q, pos_b_d;
  logic                   we_a, we_b;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;
  logic                   out_vld_q, out_vld_d, out_free, out_load;
  logic [VALUE_WIDTH-1:0] out_val_q;
  logic                   out_b_q, out_last_q;
  logic                   take_b, is_last;
  logic [CW-1:0]          pos_a_nx, pos_b_nx;

  slm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (cmd_value_i),
    .raddr_i (pos_a_q[AW-1:0]),
    .rdata_o (rd_a)
  );

  slm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (cmd_value_i),
    .raddr_i (pos_b_q[AW-1:0]),
    .rdata_o (rd_b)
  );

  assign out_free = !out_vld_q || res_ready_i;

  always_comb begin
    priority if (pos_a_q >= cnt_a_q) begin
      take_b = 1'b1;
    end else if (pos_b_q >= cnt_b_q) begin
      take_b = 1'b0;
    end else begin
      take_b = !($signed(rd_a) <= $signed(rd_b));
    end
  end

  assign pos_a_nx = pos_a_q + CW'(!take_b);
  assign pos_b_nx = pos_b_q + CW'(take_b);
  assign is_last  = (pos_a_nx == cnt_a_q) && (pos_b_nx == cnt_b_q);

  always_comb begin
    st_d        = st_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    pos_a_d     = pos_a_q;
    pos_b_d     = pos_b_q;
    cmd_ready_o = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    out_load    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          unique case (cmd_op_i)
            REQ_APPEND_A: begin
              if (cnt_a_q != CW'(LIST_DEPTH)) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + CW'(1);
              end
            end
            REQ_APPEND_B: begin
              if (cnt_b_q != CW'(LIST_DEPTH)) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + CW'(1);
              end
            end
            REQ_MERGE: begin
              pos_a_d = '0;
              pos_b_d = '0;
              if (cnt_a_q != '0 || cnt_b_q != '0) begin
                st_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          pos_a_d  = pos_a_nx;
          pos_b_d  = pos_b_nx;
          st_d     = ST_READ;
          if (is_last) begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            pos_a_d = '0;
            pos_b_d = '0;
            st_d    = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (res_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      pos_a_q   <= '0;
      pos_b_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      pos_a_q   <= pos_a_d;
      pos_b_q   <= pos_b_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= take_b ? rd_b : rd_a;
      out_b_q    <= take_b;
      out_last_q <= is_last;
    end
  end

  assign res_valid_o  = out_vld_q;
  assign res_value_o  = out_val_q;
  assign res_from_b_o = out_b_q;
  assign res_last_o   = out_last_q;

endmodule

// File: rtl/sorted_list_merger.sv
// Merges two non-decreasing lists of signed Q16.16 values. Items with req_type 0 or 1
// append their value to list A or B (LIST_DEPTH entries each; appends to a full list
// are dropped); req_type 2 emits every stored element as one non-decreasing run, A's
// element first on ties, the final result flagged by last_item, and empties both lists.
// req_type 3 is accepted and dropped. A two-entry request queue keeps taking items, until
// it is full, while a merge is in progress or a result waits. The back end handles an
// append in its idle state; in a merge each result passes a read state, for the
// registered read of the list memories, then an emit state for the compare, which waits
// until the output register is free. No reset pass is needed.
module sorted_list_merger #(
  parameter int unsigned LIST_DEPTH  = slm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = slm_pkg::VALUE_WIDTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  slm_req_if.sink   req_i,
  slm_res_if.source res_o
);
  import slm_pkg::*;

  logic                   cmd_valid, cmd_ready;
  slm_req_e               cmd_op;
  logic [VALUE_WIDTH-1:0] cmd_value;
  logic [VALUE_WIDTH-1:0] res_value;

  slm_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .req_value_i (req_i.value),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_op_o    (cmd_op),
    .cmd_value_o (cmd_value)
  );

  slm_back #(.LIST_DEPTH(LIST_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_op_i     (cmd_op),
    .cmd_value_i  (cmd_value),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_value_o  (res_value),
    .res_from_b_o (res_o.from_list_b),
    .res_last_o   (res_o.last_item)
  );

  assign res_o.merged_value = $signed(res_value);

endmodule

// File: rtl/slm_checker.sv
module slm_checker #(
  parameter int unsigned LIST_DEPTH  = slm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = slm_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic [1:0]             req_type_i,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [VALUE_WIDTH-1:0] res_value_i,
  input logic                   res_from_b_i,
  input logic                   res_last_i
);
  import slm_pkg::*;

  localparam int unsigned RW = $clog2(2 * LIST_DEPTH + 1);

  logic          seen_merge_q;
  logic [RW-1:0] run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_merge_q <= 1'b0;
      run_q        <= '0;
    end else begin
      if (req_valid_i && req_ready_i && req_type_i == REQ_MERGE) begin
        seen_merge_q <= 1'b1;
      end
      if (res_valid_i && res_ready_i) begin
        run_q <= res_last_i ? '0 : run_q + RW'(1);
      end
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_value_i)
      && $stable(res_from_b_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  a_res_after_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> seen_merge_q)
    else $error("result without a merge request");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i |-> run_q < RW'(2 * LIST_DEPTH - 1))
    else $error("merged run longer than both lists");

endmodule

bind sorted_list_merger slm_checker #(
  .LIST_DEPTH  (LIST_DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_slm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_value_i  (res_o.merged_value),
  .res_from_b_i (res_o.from_list_b),
  .res_last_i   (res_o.last_item)
);

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slm_pkg::*;

  localparam int unsigned DEPTH       = LIST_DEPTH_DEF;
  localparam int unsigned VW          = VALUE_WIDTH_DEF;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned N_ITEMS     = 470;
  localparam int unsigned N_DIR       = 25;
  localparam int unsigned N_TYPED     = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 50;

  localparam logic signed [7:0] COMPUTED = -8'sd1;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 from_b;
    logic                 last;
  } merged_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VW-1:0]     value;
    logic signed [7:0] n_typed;
  } row_t;

  localparam row_t DIR_TAB [N_DIR] = '{
    '{REQ_MERGE,    32'h0000_0000, 8'sd0},
    '{REQ_UNUSED,   32'hFFFF_FFFF, 8'sd0},
    '{REQ_APPEND_A, 32'h8000_0000, COMPUTED},
    '{REQ_APPEND_B, 32'h7FFF_FFFF, COMPUTED},
    '{REQ_MERGE,    32'h0000_0000, 8'sd2},
    '{REQ_APPEND_B, 32'hFFFF_FFFF, COMPUTED},
    '{REQ_APPEND_A, 32'h0001_0000, COMPUTED},
    '{REQ_MERGE,    32'hFFFF_FFFF, 8'sd2},
    '{REQ_APPEND_A, 32'h0000_0005, COMPUTED},
    '{REQ_APPEND_B, 32'h0000_0005, COMPUTED},
    '{REQ_MERGE,    32'h5555_AAAA, 8'sd2},
    '{REQ_APPEND_B, 32'h8000_0000, COMPUTED},
    '{REQ_MERGE,    32'h0000_0000, 8'sd1},
    '{REQ_APPEND_A, 32'h7FFF_FFFF, COMPUTED},
    '{REQ_MERGE,    32'h0000_0000, 8'sd1},
    '{REQ_APPEND_A, 32'hFFFF_0000, COMPUTED},
    '{REQ_APPEND_B, 32'h0000_0000, COMPUTED},
    '{REQ_APPEND_B, 32'h0000_8000, COMPUTED},
    '{REQ_APPEND_B, 32'h7FFF_FFFF, COMPUTED},
    '{REQ_UNUSED,   32'h0000_0000, COMPUTED},
    '{REQ_MERGE,    32'h0000_0000, COMPUTED},
    '{REQ_APPEND_A, 32'h0000_0001, COMPUTED},
    '{REQ_APPEND_A, 32'h0000_0002, COMPUTED},
    '{REQ_APPEND_B, 32'h0000_0000, COMPUTED},
    '{REQ_MERGE,    32'h0000_0000, COMPUTED}
  };

  localparam merged_t TYPED_TAB [N_TYPED] = '{
    '{32'sh8000_0000, 1'b0, 1'b0},
    '{32'sh7FFF_FFFF, 1'b1, 1'b1},
    '{32'shFFFF_FFFF, 1'b1, 1'b0},
    '{32'sh0001_0000, 1'b0, 1'b1},
    '{32'sh0000_0005, 1'b0, 1'b0},
    '{32'sh0000_0005, 1'b1, 1'b1},
    '{32'sh8000_0000, 1'b1, 1'b1},
    '{32'sh7FFF_FFFF, 1'b0, 1'b1}
  };

  logic clk;
  logic rst_n;

  slm_req_if req_bus ();
  slm_res_if res_bus ();

  sorted_list_merger u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  row_t                 stim_q [$];
  merged_t              merged_q [$];
  logic signed [VW-1:0] list_a [DEPTH];
  logic signed [VW-1:0] list_b [DEPTH];
  int unsigned          count_a = 0;
  int unsigned          count_b = 0;
  int unsigned          n_accepted = 0;
  int unsigned          typed_pos = 0;
  int unsigned          n_errors = 0;

  function automatic void merge_step(logic [1:0] kind, logic signed [VW-1:0] v, bit keep);
    int unsigned ia;
    int unsigned ib;
    int unsigned total;
    bit          take_b;
    merged_t     r;
    ia = 0;
    ib = 0;
    total = count_a + count_b;
    case (kind)
      REQ_APPEND_A: begin
        if (count_a < DEPTH) begin
          list_a[count_a] = v;
          count_a++;
        end
      end
      REQ_APPEND_B: begin
        if (count_b < DEPTH) begin
          list_b[count_b] = v;
          count_b++;
        end
      end
      REQ_MERGE: begin
        for (int unsigned n = 0; n < total; n++) begin
          if (ia >= count_a) take_b = 1'b1;
          else if (ib >= count_b) take_b = 1'b0;
          else take_b = (list_a[ia] > list_b[ib]);
          if (take_b) begin
            r.value = list_b[ib];
            ib++;
          end else begin
            r.value = list_a[ia];
            ia++;
          end
          r.from_b = take_b;
          r.last   = (n + 1 == total);
          if (keep) merged_q.push_back(r);
        end
        count_a = 0;
        count_b = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [VW-1:0] want, logic [VW-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) $error("%s: expected %0h, got %0h", field, want, got);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int unsigned burst;
    int unsigned gap;
    int unsigned na;
    int unsigned nb;
    bit          first;
    bit          narrow;
    bit          broken;
    int          qa [$];
    int          qb [$];

    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_APPEND_A;
    req_bus.value    <= '0;

    foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
    first   = 1'b1;
    while (stim_q.size() < N_ITEMS) begin
      if (first) begin
        na    = DEPTH + 2;
        nb    = DEPTH + 1;
        first = 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            na = $urandom_range(DEPTH - 2, DEPTH + 4);
            nb = $urandom_range(0, DEPTH + 4);
          end
          1: begin
            na = $urandom_range(0, DEPTH + 4);
            nb = $urandom_range(DEPTH - 2, DEPTH + 4);
          end
          2: begin
            na = 0;
            nb = 0;
          end
          default: begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
          end
        endcase
      end

      narrow = ($urandom_range(0, 3) == 0);
      broken = ($urandom_range(0, 9) == 0);
      qa.delete();
      qb.delete();
      repeat (na) qa.push_back(narrow ? (int'($urandom_range(0, 7)) - 4) <<< 16 : int'($urandom));
      repeat (nb) qb.push_back(narrow ? (int'($urandom_range(0, 7)) - 4) <<< 16 : int'($urandom));
      if (!broken) begin
        qa.sort();
        qb.sort();
      end
      while (qa.size() + qb.size() > 0) begin
        if ($urandom_range(0, 14) == 0) stim_q.push_back(row_t'{REQ_UNUSED, $urandom, COMPUTED});
        if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1) == 0)) begin
          stim_q.push_back(row_t'{REQ_APPEND_A, qa.pop_front(), COMPUTED});
        end else begin
          stim_q.push_back(row_t'{REQ_APPEND_B, qb.pop_front(), COMPUTED});
        end
      end
      stim_q.push_back(row_t'{REQ_MERGE, $urandom, COMPUTED});
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    burst = 0;
    foreach (stim_q[i]) begin
      if (burst == 0) begin
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst = $urandom_range(1, 24);
        repeat (gap) begin
          req_bus.valid <= 1'b0;
          @(posedge clk);
        end
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= stim_q[i].kind;
      req_bus.value    <= stim_q[i].value;
      @(posedge clk);
      while (!req_bus.ready) @(posedge clk);
      burst--;
    end
    req_bus.valid <= 1'b0;
    @(posedge clk);

    while (merged_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    bit          held;
    res_bus.ready <= 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      if (!held && n_accepted > N_DIR + 150) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          res_bus.ready <= 1'b0;
          @(posedge clk);
        end
      end
      for (int unsigned c = 0; c < span; c++) begin
        case (mode)
          0:       res_bus.ready <= 1'b1;
          1:       res_bus.ready <= ($urandom_range(0, 1) == 1);
          2:       res_bus.ready <= (c % 4 == 3);
          default: res_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // predict on every accepted item; typed rows supply their own results
  always @(posedge clk) begin
    if (rst_n && req_bus.valid && req_bus.ready) begin
      if (stim_q[n_accepted].n_typed == COMPUTED) begin
        merge_step(req_bus.req_type, req_bus.value, 1'b1);
      end else begin
        merge_step(req_bus.req_type, req_bus.value, 1'b0);
        repeat (stim_q[n_accepted].n_typed) begin
          merged_q.push_back(TYPED_TAB[typed_pos]);
          typed_pos++;
        end
      end
      n_accepted++;
    end
  end

  always @(posedge clk) begin
    merged_t want;
    if (res_bus.valid && res_bus.ready) begin
      if (merged_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $error("unexpected item: merged_value %0h", res_bus.merged_value);
        end
      end else begin
        want = merged_q.pop_front();
        check_field("merged_value", want.value, res_bus.merged_value);
        check_field("from_list_b", VW'(want.from_b), VW'(res_bus.from_list_b));
        check_field("last_item", VW'(want.last), VW'(res_bus.last_item));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/slm_pkg.sv
rtl/slm_if.sv
rtl/slm_ram.sv
rtl/slm_front.sv
rtl/slm_back.sv
rtl/sorted_list_merger.sv
rtl/slm_checker.sv
tb/tb_top.sv
